/* src/step_enlarge_weighted_decimator_core_assert.svh */
`ifndef STEP_ENLARGE_WEIGHTED_DECIMATOR_CORE_ASSERT_SVH
`define STEP_ENLARGE_WEIGHTED_DECIMATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SEWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SEWD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sewd_pkg.sv */
package sewd_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int FACTOR_W   = 7;
  localparam int MIN_FACTOR = 2;
  localparam int MAX_FACTOR = 64;
  localparam int H_W        = $clog2(MAX_FACTOR);
  localparam int F_W        = $clog2(MAX_FACTOR + 1);
  localparam int WIN_DEPTH  = 2 * MAX_FACTOR;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);
  localparam int BACK_W     = WIN_AW + 2;
  localparam int ACC_W      = SAMPLE_W + H_W + 2;
  localparam int QUO_W      = ACC_W - 3;
  localparam int DCNT_W     = $clog2(QUO_W);
  localparam int GRP_W      = 2;

  typedef logic [1:0] osel_t;

  localparam osel_t OSEL_HOLD = 2'd0;
  localparam osel_t OSEL_ZERO = 2'd1;
  localparam osel_t OSEL_QUOT = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic [WIN_AW-1:0] wr_addr;
    logic              hold_en;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_addr;
    logic              rd_zero;
    logic              rd_center;
    logic              acc_clr;
    logic [H_W-1:0]    h;
    logic              div_start;
    logic              out_load;
    osel_t             out_sel;
    logic              out_final;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* src/sewd_if.sv */
interface sewd_in_if;
  import sewd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       is_last;
  modport source (output valid, sample, is_last, input ready);
  modport sink (input valid, sample, is_last, output ready);
endinterface

interface sewd_out_if;
  import sewd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] value;
  logic                       is_final;
  modport source (output valid, value, is_final, input ready);
  modport sink (input valid, value, is_final, output ready);
endinterface

/* src/sewd_dpath.sv */
module sewd_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sewd_pkg::dp_cmd_t                   cmd,
  input  logic signed [sewd_pkg::SAMPLE_W-1:0] sample,
  output sewd_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sewd_pkg::SAMPLE_W-1:0] out_value,
  output logic                                out_is_final
);
  import sewd_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [SAMPLE_W-1:0] win_mem [WIN_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic signed [SAMPLE_W-1:0] hold_r;
  logic                       tap_vld_r;
  logic                       tap_zero_r;
  logic                       tap_ctr_r;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] rd_ext;
  logic signed [ACC_W-1:0] wt_ext;
  logic signed [ACC_W-1:0] tap_term;

  logic [ACC_W-1:0]  mag;
  logic [ACC_W-1:0]  rnd;
  logic [QUO_W-1:0]  quo_r;
  logic [H_W-1:0]    rem_r;
  logic [H_W:0]      rem_sh;
  logic [H_W:0]      rem_sub;
  logic              fits;
  logic [DCNT_W-1:0] dcnt_r;
  logic              div_busy_r;
  logic              div_done_r;
  logic              neg_r;

  logic signed [ACC_W-1:0] q_ext;
  logic signed [ACC_W-1:0] q_sgn;
  logic signed [ACC_W-1:0] q_sat;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] value_r;
  logic                       final_r;

  // window memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      win_mem[cmd.wr_addr] <= sample;
    end
    if (cmd.rd_en) begin
      rd_data_r <= win_mem[cmd.rd_addr];
    end
    if (cmd.hold_en) begin
      hold_r <= sample;
    end
    tap_zero_r <= cmd.rd_zero;
    tap_ctr_r  <= cmd.rd_center;
  end

  assign rd_ext   = ACC_W'(rd_data_r);
  assign wt_ext   = ACC_W'({1'b0, cmd.h, 1'b0});
  assign tap_term = tap_ctr_r ? rd_ext * wt_ext : rd_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_vld_r <= 1'b0;
    end else begin
      tap_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (tap_vld_r && !tap_zero_r) begin
      acc_r <= acc_r + tap_term;
    end
  end

  // round half away from zero: (|num| + 2h) / 4h == ((|num| + 2h) >> 2) / h
  assign mag     = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign rnd     = mag + ACC_W'({cmd.h, 1'b0});
  assign rem_sh  = {rem_r, quo_r[QUO_W-1]};
  assign fits    = rem_sh >= {1'b0, cmd.h};
  assign rem_sub = rem_sh - {1'b0, cmd.h};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= rnd[ACC_W-2:2];
      rem_r <= '0;
      neg_r <= acc_r[ACC_W-1];
    end else if (div_busy_r) begin
      quo_r <= {quo_r[QUO_W-2:0], fits};
      rem_r <= fits ? rem_sub[H_W-1:0] : rem_sh[H_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
      dcnt_r     <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_done_r <= 1'b0;
      dcnt_r     <= DCNT_W'(QUO_W - 1);
    end else if (div_busy_r) begin
      if (dcnt_r == '0) begin
        div_busy_r <= 1'b0;
        div_done_r <= 1'b1;
      end else begin
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end
    end else begin
      div_done_r <= 1'b0;
    end
  end

  assign q_ext = ACC_W'(quo_r);
  assign q_sgn = neg_r ? -q_ext : q_ext;

  always_comb begin
    priority if (q_sgn > SAT_HI) begin
      q_sat = SAT_HI;
    end else if (q_sgn < SAT_LO) begin
      q_sat = SAT_LO;
    end else begin
      q_sat = q_sgn;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      final_r <= cmd.out_final;
      unique case (cmd.out_sel)
        OSEL_HOLD: value_r <= hold_r;
        OSEL_ZERO: value_r <= '0;
        OSEL_QUOT: value_r <= q_sat[SAMPLE_W-1:0];
        default:   value_r <= '0;
      endcase
    end
  end

  assign stat.div_done = div_done_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_value    = value_r;
  assign out_is_final = final_r;

endmodule

/* src/sewd_ctrl.sv */
module sewd_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_is_last,
  output logic                            in_ready,
  input  logic                            cfg_we,
  input  logic [sewd_pkg::FACTOR_W-1:0]   cfg_data,
  output sewd_pkg::dp_cmd_t               cmd,
  input  sewd_pkg::dp_stat_t              stat
);
  import sewd_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SUM      = 3'd1;
  localparam logic [2:0] ST_FLUSH    = 3'd2;
  localparam logic [2:0] ST_DIV_GO   = 3'd3;
  localparam logic [2:0] ST_DIV_WAIT = 3'd4;
  localparam logic [2:0] ST_EMIT_MID = 3'd5;
  localparam logic [2:0] ST_EMIT_FIN = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [FACTOR_W-1:0] factor_r;
  logic [F_W-1:0]      active_f_r, active_f_nxt;
  logic [WIN_AW-1:0]   wpos_r, wpos_nxt;
  logic [H_W-1:0]      phase_r, phase_nxt;
  logic [GRP_W-1:0]    group_r, group_nxt;
  logic                started_r, started_nxt;
  logic                fin_pend_r, fin_pend_nxt;
  logic                fin_flag_r, fin_flag_nxt;
  osel_t               fin_sel_r, fin_sel_nxt;
  logic [F_W-1:0]      cb_r, cb_nxt;
  logic [H_W-1:0]      h_r, h_nxt;
  logic [BACK_W-1:0]   back_r, back_nxt;
  logic [BACK_W-1:0]   back_end_r, back_end_nxt;

  logic                accept;
  logic [F_W-1:0]      f_clamp;
  logic [F_W-1:0]      ph_inc;
  logic                ph_wrap;
  logic [GRP_W-1:0]    grp_inc;
  logic [GRP_W-1:0]    grp_new;
  logic [WIN_AW-1:0]   wpos_inc;
  logic [H_W-1:0]      f_m1;
  logic [H_W-1:0]      f_half;
  logic [WIN_AW:0]     diff;
  logic [WIN_AW:0]     diff_wrap;
  logic                start_sum;
  logic [F_W-1:0]      cb_sel;
  logic [H_W-1:0]      h_sel;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    priority if (int'(factor_r) < MIN_FACTOR) begin
      f_clamp = F_W'(MIN_FACTOR);
    end else if (int'(factor_r) > MAX_FACTOR) begin
      f_clamp = F_W'(MAX_FACTOR);
    end else begin
      f_clamp = F_W'(factor_r);
    end
  end

  assign ph_inc    = F_W'(phase_r) + F_W'(1);
  assign ph_wrap   = ph_inc >= active_f_r;
  assign grp_inc   = (group_r == '1) ? group_r : group_r + GRP_W'(1);
  assign grp_new   = ph_wrap ? grp_inc : group_r;
  assign wpos_inc  = (wpos_r == WIN_AW'(WIN_DEPTH - 1)) ? '0 : wpos_r + WIN_AW'(1);
  assign f_m1      = H_W'(active_f_r - F_W'(1));
  assign f_half    = H_W'(active_f_r >> 1);
  assign diff      = {1'b0, wpos_r} - {1'b0, back_r[WIN_AW-1:0]};
  assign diff_wrap = diff + (WIN_AW + 1)'(WIN_DEPTH);

  always_comb begin
    state_nxt    = state_r;
    active_f_nxt = active_f_r;
    wpos_nxt     = wpos_r;
    phase_nxt    = phase_r;
    group_nxt    = group_r;
    started_nxt  = started_r;
    fin_pend_nxt = fin_pend_r;
    fin_flag_nxt = fin_flag_r;
    fin_sel_nxt  = fin_sel_r;
    cb_nxt       = cb_r;
    h_nxt        = h_r;
    back_nxt     = back_r;
    back_end_nxt = back_end_r;
    start_sum    = 1'b0;
    cb_sel       = active_f_r;
    h_sel        = f_m1;
    cmd          = '0;
    cmd.h        = h_r;
    cmd.out_sel  = OSEL_ZERO;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.wr_en   = 1'b1;
          cmd.hold_en = 1'b1;
          if (!started_r) begin
            active_f_nxt = f_clamp;
            wpos_nxt     = '0;
            cmd.wr_addr  = '0;
            phase_nxt    = '0;
            group_nxt    = '0;
            started_nxt  = !in_is_last;
            fin_sel_nxt  = OSEL_HOLD;
            fin_flag_nxt = in_is_last;
            state_nxt    = ST_EMIT_FIN;
          end else begin
            wpos_nxt    = wpos_inc;
            cmd.wr_addr = wpos_inc;
            if (!in_is_last) begin
              phase_nxt = ph_wrap ? '0 : ph_inc[H_W-1:0];
              group_nxt = grp_new;
              if (ph_wrap && grp_new >= GRP_W'(2)) begin
                start_sum    = 1'b1;
                fin_pend_nxt = 1'b0;
                cb_sel       = active_f_r;
                h_sel        = (grp_new == GRP_W'(2)) ? f_m1 : f_half;
              end
            end else begin
              started_nxt  = 1'b0;
              phase_nxt    = '0;
              group_nxt    = '0;
              fin_flag_nxt = 1'b1;
              fin_sel_nxt  = ph_wrap ? OSEL_HOLD : OSEL_ZERO;
              if (grp_new >= GRP_W'(2) || (grp_new == GRP_W'(1) && !ph_wrap)) begin
                start_sum    = 1'b1;
                fin_pend_nxt = 1'b1;
                cb_sel       = ph_wrap ? active_f_r : ph_inc;
                h_sel        = f_m1;
              end else begin
                state_nxt = ST_EMIT_FIN;
              end
            end
          end
        end
      end
      ST_SUM: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr   = diff[WIN_AW] ? diff_wrap[WIN_AW-1:0] : diff[WIN_AW-1:0];
        cmd.rd_zero   = back_r[BACK_W-1];
        cmd.rd_center = (back_r == BACK_W'(cb_r));
        back_nxt      = back_r + BACK_W'(1);
        if (back_r == back_end_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_EMIT_MID;
        end
      end
      ST_EMIT_MID: begin
        cmd.out_sel = OSEL_QUOT;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = fin_pend_r ? ST_EMIT_FIN : ST_IDLE;
        end
      end
      ST_EMIT_FIN: begin
        cmd.out_sel   = fin_sel_r;
        cmd.out_final = fin_flag_r;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (start_sum) begin
      cmd.acc_clr  = 1'b1;
      cb_nxt       = cb_sel;
      h_nxt        = h_sel;
      back_nxt     = BACK_W'(cb_sel) - BACK_W'(h_sel);
      back_end_nxt = BACK_W'(cb_sel) + BACK_W'(h_sel);
      state_nxt    = ST_SUM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      factor_r   <= FACTOR_W'(MIN_FACTOR);
      active_f_r <= F_W'(MIN_FACTOR);
      wpos_r     <= '0;
      phase_r    <= '0;
      group_r    <= '0;
      started_r  <= 1'b0;
      fin_pend_r <= 1'b0;
      fin_flag_r <= 1'b0;
      fin_sel_r  <= OSEL_ZERO;
    end else begin
      state_r    <= state_nxt;
      active_f_r <= active_f_nxt;
      wpos_r     <= wpos_nxt;
      phase_r    <= phase_nxt;
      group_r    <= group_nxt;
      started_r  <= started_nxt;
      fin_pend_r <= fin_pend_nxt;
      fin_flag_r <= fin_flag_nxt;
      fin_sel_r  <= fin_sel_nxt;
      if (cfg_we) begin
        factor_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cb_r       <= cb_nxt;
    h_r        <= h_nxt;
    back_r     <= back_nxt;
    back_end_r <= back_end_nxt;
  end

endmodule

/* src/step_enlarge_weighted_decimator_core.sv */
// Channel  Direction  Beat contents              Handshake
// in_ch    in         sample[23:0], is_last      valid / ready
// out_ch   out        value[23:0], is_final      valid / ready
// cfg      in         cfg_data[6:0] = factor     cfg_we, one cycle
//
// A beat that completes no output leaves the core ready for the next beat; with F = factor,
// that is F-1 of every F in the middle of a record. A record's first beat is stored, then loaded as output 0.
// A beat that completes a middle output runs the window memory read loop over 2h+1 taps
// (h = half-width, one tap a cycle), then the 29-step divider.
// A record's last beat also loads the final result as one more output.
// Reset is synchronous; the window needs no clearing pass.
// A finished result waits in the output register; beats that complete no output
// are still taken while it waits.
module step_enlarge_weighted_decimator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  sewd_in_if.sink                       in_ch,
  sewd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [sewd_pkg::FACTOR_W-1:0] cfg_data
);
  import sewd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sewd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_is_last (in_ch.is_last),
    .in_ready   (in_ch.ready),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat)
  );

  sewd_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sample       (in_ch.sample),
    .stat         (stat),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_value    (out_ch.value),
    .out_is_final (out_ch.is_final)
  );

endmodule

/* src/sewd_chk.sv */
`include "step_enlarge_weighted_decimator_core_assert.svh"

module sewd_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_is_last,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [sewd_pkg::SAMPLE_W-1:0] out_value,
  input logic                                out_is_final
);
  import sewd_pkg::*;

  // hold a stalled result
  `SEWD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_is_final), "stalled result changed")
  // a record's last beat always leaves a final result to produce
  `SEWD_ASSERT_NXT(a_last_busy, in_valid && in_ready && in_is_last, !in_ready, "ready after last beat")
  // no result right out of reset
  `SEWD_ASSERT_NOW(a_rst_empty, $past(!rst_n), !out_valid, "result valid after reset")

endmodule

bind step_enlarge_weighted_decimator_core sewd_chk u_sewd_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_is_last   (in_ch.is_last),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_value    (out_ch.value),
  .out_is_final (out_ch.is_final)
);

/* verif/step_enlarge_weighted_decimator_core_test.sv */
module step_enlarge_weighted_decimator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sewd_pkg::*;

  localparam int LIMIT_CYCLES  = 3000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS   = 90;
  localparam int NUM_PHASES    = 14;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       is_final;
  } decim_out_t;

  class decim_scoreboard;
    logic [FACTOR_W-1:0]        factor_reg;
    logic signed [SAMPLE_W-1:0] window [WIN_DEPTH];
    int                         wr_pos;
    int                         phase_cnt;
    int                         group_cnt;
    int                         rec_factor;
    bit                         in_record;
    decim_out_t                 expected_q [$];
    int                         errors;

    function new();
      factor_reg = FACTOR_W'(MIN_FACTOR);
      foreach (window[i]) window[i] = '0;
      wr_pos     = 0;
      phase_cnt  = 0;
      group_cnt  = 0;
      rec_factor = MIN_FACTOR;
      in_record  = 1'b0;
      errors     = 0;
    endfunction

    function void write_factor(logic [FACTOR_W-1:0] v);
      factor_reg = v;
    endfunction

    function void queue_result(decim_out_t res);
      expected_q.insert(expected_q.size(), res);
    endfunction

    function int effective_factor();
      if (factor_reg < MIN_FACTOR) return MIN_FACTOR;
      if (factor_reg > MAX_FACTOR) return MAX_FACTOR;
      return int'(factor_reg);
    endfunction

    function logic signed [SAMPLE_W-1:0] tap(int back);
      if (back < 0 || back >= WIN_DEPTH) return '0;
      return window[(wr_pos + WIN_DEPTH - back) % WIN_DEPTH];
    endfunction

    function logic signed [SAMPLE_W-1:0] weighted_mean(int cb, int h);
      longint num;
      longint den;
      longint q;
      longint hi;
      longint lo;
      hi  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
      lo  = -hi - 1;
      num = 2 * longint'(h) * longint'(tap(cb));
      den = 4 * longint'(h);
      for (int k = 1; k <= h; k++) begin
        num += longint'(tap(cb - k)) + longint'(tap(cb + k));
      end
      if (num >= 0) begin
        q = (num + den / 2) / den;
      end else begin
        q = -((-num + den / 2) / den);
      end
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return q[SAMPLE_W-1:0];
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic last);
      int                         f;
      int                         h;
      int                         cb;
      logic signed [SAMPLE_W-1:0] fin;
      if (!in_record) begin
        rec_factor = effective_factor();
        wr_pos     = 0;
        window[0]  = smp;
        phase_cnt  = 0;
        group_cnt  = 0;
        queue_result('{value: smp, is_final: last});
        in_record  = !last;
        return;
      end
      f = rec_factor;
      wr_pos = (wr_pos + 1) % WIN_DEPTH;
      window[wr_pos] = smp;
      phase_cnt++;
      if (phase_cnt >= f) begin
        phase_cnt = 0;
        if (group_cnt < 3) group_cnt++;
      end
      if (!last) begin
        if (phase_cnt == 0 && group_cnt >= 2) begin
          h = (group_cnt == 2) ? f - 1 : f / 2;
          queue_result('{value: weighted_mean(f, h), is_final: 1'b0});
        end
        return;
      end
      if (group_cnt >= 2 || (group_cnt == 1 && phase_cnt > 0)) begin
        cb = (phase_cnt == 0) ? f : phase_cnt;
        queue_result('{value: weighted_mean(cb, f - 1), is_final: 1'b0});
      end
      fin = (phase_cnt == 0) ? smp : '0;
      queue_result('{value: fin, is_final: 1'b1});
      in_record = 1'b0;
      phase_cnt = 0;
      group_cnt = 0;
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] value, logic is_final);
      decim_out_t exp_out;
      if (expected_q.size() == 0) begin
        $error("unexpected output beat: value %0d is_final %0b", value, is_final);
        errors++;
        return;
      end
      exp_out = expected_q.pop_front();
      if (value !== exp_out.value) begin
        $error("value mismatch: expected %0d, got %0d", exp_out.value, value);
        errors++;
      end
      if (is_final !== exp_out.is_final) begin
        $error("is_final mismatch: expected %0b, got %0b", exp_out.is_final, is_final);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [FACTOR_W-1:0] cfg_data;
  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;

  sewd_in_if  in_bus ();
  sewd_out_if out_bus ();

  decim_scoreboard sb = new();

  step_enlarge_weighted_decimator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("step_enlarge_weighted_decimator_core verification failed");
    $finish;
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        sb.check_output(out_bus.value, out_bus.is_final);
      end
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2, 3: return SAMPLE_W'($urandom_range(16)) - SAMPLE_W'(8);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic int record_len(int f);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 1;
    if (r < 30) return $urandom_range(f + 1, 2);
    if (r < 45) return $urandom_range(4, 1) * f + 1;
    if (r < 90) return $urandom_range(4 * f + 3, f + 2);
    return $urandom_range(6 * f, 4 * f);
  endfunction

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 85; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 85; end
      default: begin send_idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  task automatic send_beat(input logic [SAMPLE_W-1:0] smp, input logic last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_bus.valid   <= 1'b1;
    in_bus.sample  <= smp;
    in_bus.is_last <= last;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_sample(smp, last);
  endtask

  task automatic write_factor(input logic [FACTOR_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    sb.write_factor(v);
    cfg_we   <= 1'b0;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [SAMPLE_W-1:0] vals [22] = '{
      24'h7FFFFF,
      24'h800000,
      24'hFFFFFF, 24'h000001,
      24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
      24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h000000,
      24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h000001, 24'hFFFFFF, 24'h000002,
      24'hFFFFFE
    };
    bit ends [22] = '{1, 1, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1};
    for (int i = 0; i < 22; i++) begin
      send_beat(vals[i], ends[i]);
    end
  endtask

  task automatic run_random(input int budget);
    int sent;
    int len;
    int f;
    sent = 0;
    f = sb.effective_factor();
    while (sent < budget) begin
      len = record_len(f);
      for (int i = 0; i < len; i++) begin
        send_beat(rand_sample(), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    int unsigned factor_plan [12] = '{2, 64, 0, 3, 127, 1, 5, 4, 9, 65, 16, 6};
    logic [FACTOR_W-1:0] fv;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    in_bus.is_last = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(0);
    run_directed();
    drain();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 12) begin
        fv = FACTOR_W'(factor_plan[ph]);
      end else if (ph == 12) begin
        fv = FACTOR_W'($urandom_range(12, 2));
      end else begin
        fv = FACTOR_W'($urandom_range(127));
      end
      set_idle(ph % 4);
      write_factor(fv);
      run_random(PHASE_ITEMS);
      drain();
    end
    if (sb.errors == 0) begin
      $display("step_enlarge_weighted_decimator_core verification clean");
    end else begin
      $display("step_enlarge_weighted_decimator_core verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/sewd_pkg.sv
src/sewd_if.sv
src/sewd_dpath.sv
src/sewd_ctrl.sv
src/step_enlarge_weighted_decimator_core.sv
src/sewd_chk.sv
verif/step_enlarge_weighted_decimator_core_test.sv
